// ===== rtl/core/arpc_pkg.sv =====
// Shared types and constants for the ARP cache and responder.
`default_nettype none

package arpc_pkg;

   localparam int ARPC_CACHE_ENTRIES = 64;

   // ARP header constants
   localparam logic [15:0] HW_ETHERNET = 16'h0001;
   localparam logic [15:0] PROTO_IPV4  = 16'h0800;
   localparam logic [15:0] OP_REQUEST  = 16'h0001;

   // result status codes
   localparam logic [2:0] STATUS_HANDLED  = 3'd0;
   localparam logic [2:0] STATUS_RESOLVED = 3'd1;
   localparam logic [2:0] STATUS_REQUEST  = 3'd2;
   localparam logic [2:0] STATUS_NO_IFACE = 3'd3;
   localparam logic [2:0] STATUS_DROPPED  = 3'd4;

   // configuration register indexes
   localparam logic [1:0] CSR_OWN_IP        = 2'd0;
   localparam logic [1:0] CSR_OWN_MAC       = 2'd1;
   localparam logic [1:0] CSR_IFACE_PRESENT = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PKT,
      ST_SCAN,
      ST_FIN
   } arpc_state_type;

   // controller to datapath
   typedef struct packed {
      logic capture;   // latch the accepted request
      logic scan;      // cache lookup in progress
      logic load;      // write result into the output register
   } arpc_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_query;
      logic scan_done;
      logic out_free;
   } arpc_status_type;

endpackage

`default_nettype wire

// ===== rtl/core/arp_cache_responder_top.sv =====
// Sequence: packet, accept in ST_IDLE, then load in ST_PKT; query, accept, ST_PKT, then a
//   scan in ST_SCAN over the n filled entries (one entry read per cycle from the cache
//   memory) up to a hit or the last entry, then load in ST_FIN; rsp_tvalid is registered.
// Flow: one transaction at a time, accepted the cycle after the result is loaded;
//   a waiting result holds the load.
// Reset: synchronous; clears the fill count (all entries invalid) at once, no sweep.
`default_nettype none

module arp_cache_responder_top
   import arpc_pkg::*;
#(
   parameter int CACHE_ENTRIES = ARPC_CACHE_ENTRIES
) (
   input  wire logic          clock,
   input  wire logic          reset,
   // configuration write channel
   input  wire logic          csr_valid,
   output logic               csr_ready,
   input  wire logic [1:0]    csr_index,
   input  wire logic [47:0]   csr_data,
   // request stream
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic          req_tuser,   // action
   // frame_short, hw_type, proto_type, operation, sender_mac, sender_ip,
   // target_ip, query_ip, zero pad
   input  wire logic [199:0]  req_tdata,
   // result stream
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [2:0]         rsp_tuser,   // status
   // resolved_mac, learned, send_reply, reply_dest_mac, reply_dest_ip,
   // send_request, request_ip, zero pad
   output logic [167:0]       rsp_tdata
);

   arpc_cmd_type    cmd;
   arpc_status_type stat;

   assign csr_ready = 1'b1;

   arpc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   arpc_dp #(
      .CACHE_ENTRIES (CACHE_ENTRIES)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .stat       (stat)
   );

endmodule

`default_nettype wire

// ===== rtl/core/arpc_ctrl.sv =====
// Sequencer for the ARP cache: accept, learn or scan, and result hand-off.
`default_nettype none

module arpc_ctrl
   import arpc_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_tvalid,
   output logic                 req_tready,
   input  wire arpc_status_type stat,
   output arpc_cmd_type         cmd
);

   arpc_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      cmd.capture = 1'b0;
      cmd.scan    = 1'b0;
      cmd.load    = 1'b0;
      req_tready  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_PKT;
            end
         end
         ST_PKT: begin
            // query branches into the lookup, packet goes straight to result
            if (stat.is_query) begin
               state_in = ST_SCAN;
            end else if (stat.out_free) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_done) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (stat.out_free) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/core/arpc_dp.sv =====
// ARP cache datapath: config registers, cache memory, lookup and output register.
`default_nettype none

module arpc_dp
   import arpc_pkg::*;
#(
   parameter int CACHE_ENTRIES = ARPC_CACHE_ENTRIES
) (
   input  wire logic          clock,
   input  wire logic          reset,
   // configuration
   input  wire logic          csr_valid,
   input  wire logic [1:0]    csr_index,
   input  wire logic [47:0]   csr_data,
   // request payload
   input  wire logic          req_tuser,
   input  wire logic [199:0]  req_tdata,
   // result
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [2:0]         rsp_tuser,
   output logic [167:0]       rsp_tdata,
   // control
   input  wire arpc_cmd_type  cmd,
   output arpc_status_type    stat
);

   localparam int AW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
   localparam int CW = $clog2(CACHE_ENTRIES + 1);
   localparam logic [CW-1:0] FULL = CW'(CACHE_ENTRIES);

   // configuration; own MAC is not needed by any result, so writes to it are dropped
   logic [31:0] own_ip_ff;
   logic        iface_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_ip_ff <= '0;
         iface_ff  <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_OWN_IP:        own_ip_ff <= csr_data[31:0];
            CSR_IFACE_PRESENT: iface_ff  <= csr_data[0];
            default: ;
         endcase
      end
   end

   // captured request
   logic        action_ff;
   logic        short_ff;
   logic [15:0] hw_ff, proto_ff, op_ff;
   logic [47:0] smac_ff;
   logic [31:0] sip_ff, tip_ff, qip_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         action_ff <= req_tuser;
         short_ff  <= req_tdata[0];
         hw_ff     <= req_tdata[16:1];
         proto_ff  <= req_tdata[32:17];
         op_ff     <= req_tdata[48:33];
         smac_ff   <= req_tdata[96:49];
         sip_ff    <= req_tdata[128:97];
         tip_ff    <= req_tdata[160:129];
         qip_ff    <= req_tdata[192:161];
      end
   end

   // cache: entries below the fill count are exactly the valid ones
   logic [79:0]   mem [CACHE_ENTRIES];
   logic [79:0]   rd_data_ff;
   logic [CW-1:0] fill_ff, fill_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic          pend_ff, pend_in;
   logic          hit_ff;
   logic [47:0]   hit_mac_ff;

   logic drop, room, learn, reply, more, match, issue, done;

   assign drop  = short_ff || (hw_ff != HW_ETHERNET) || (proto_ff != PROTO_IPV4);
   assign room  = (fill_ff < FULL);
   assign learn = !drop && room;
   assign reply = !drop && (op_ff == OP_REQUEST) && (tip_ff == own_ip_ff);

   assign more  = (idx_ff < fill_ff);
   assign match = pend_ff && (rd_data_ff[31:0] == qip_ff);
   assign done  = match || !more;
   assign issue = cmd.scan && !done;

   always_comb begin
      fill_in = fill_ff;
      if (cmd.load && !action_ff && learn) begin
         fill_in = fill_ff + CW'(1);
      end
      idx_in = idx_ff;
      if (cmd.capture) begin
         idx_in = '0;
      end else if (issue) begin
         idx_in = idx_ff + CW'(1);
      end
      pend_in = issue;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         idx_ff  <= '0;
         pend_ff <= 1'b0;
      end else begin
         fill_ff <= fill_in;
         idx_ff  <= idx_in;
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load && !action_ff && learn) begin
         mem[fill_ff[AW-1:0]] <= {smac_ff, sip_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         rd_data_ff <= mem[idx_ff[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan && done) begin
         hit_ff     <= match;
         hit_mac_ff <= rd_data_ff[79:32];
      end
   end

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  status_ff, status_in;
   logic [47:0] rmac_ff, rmac_in;
   logic        learned_ff, learned_in;
   logic        sreply_ff, sreply_in;
   logic [47:0] dmac_ff, dmac_in;
   logic [31:0] dip_ff, dip_in;
   logic        sreq_ff, sreq_in;
   logic [31:0] reqip_ff, reqip_in;

   always_comb begin
      status_in  = STATUS_HANDLED;
      rmac_in    = '0;
      learned_in = 1'b0;
      sreply_in  = 1'b0;
      dmac_in    = '0;
      dip_in     = '0;
      sreq_in    = 1'b0;
      reqip_in   = '0;
      if (!action_ff) begin
         if (drop) begin
            status_in = STATUS_DROPPED;
         end else begin
            learned_in = room;
            sreply_in  = reply;
            if (reply) begin
               dmac_in = smac_ff;
               dip_in  = sip_ff;
            end
         end
      end else if (hit_ff) begin
         status_in = STATUS_RESOLVED;
         rmac_in   = hit_mac_ff;
      end else if (iface_ff) begin
         status_in = STATUS_REQUEST;
         sreq_in   = 1'b1;
         reqip_in  = qip_ff;
      end else begin
         status_in = STATUS_NO_IFACE;
      end
   end

   assign stat.out_free  = !rsp_valid_ff || rsp_tready;
   assign stat.is_query  = action_ff;
   assign stat.scan_done = done;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         status_ff  <= status_in;
         rmac_ff    <= rmac_in;
         learned_ff <= learned_in;
         sreply_ff  <= sreply_in;
         dmac_ff    <= dmac_in;
         dip_ff     <= dip_in;
         sreq_ff    <= sreq_in;
         reqip_ff   <= reqip_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = status_ff;
   assign rsp_tdata  = {5'd0, reqip_ff, sreq_ff, dip_ff, dmac_ff,
                        sreply_ff, learned_ff, rmac_ff};

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FULL)
      else $error("fill count beyond cache size");

   a_fill_step: assert property (@(posedge clock) disable iff (reset)
      (cmd.load && !action_ff && learn) |=> (fill_ff == $past(fill_ff) + CW'(1)))
      else $error("learned entry did not advance fill count");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      issue |-> (idx_ff < fill_ff))
      else $error("lookup read beyond filled entries");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (!rsp_valid_ff || rsp_tready))
      else $error("result loaded over a pending result");

endmodule

`default_nettype wire
